>>> src/sorted_key_equal_range_search_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key equal range search core.
// Each macro expands to one labeled concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_EQUAL_RANGE_SEARCH_CORE_MACROS_SVH
`define SORTED_KEY_EQUAL_RANGE_SEARCH_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKSE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKSE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/skse_pkg.sv
// ----------------------------------------------------------------------------
// skse_pkg
// Shared constants and operation codes of the sorted key equal range search.
// ----------------------------------------------------------------------------
package skse_pkg;

    // Each letter of a key is packed as a 5-bit code.
    localparam int LETTER_BITS = 5;

    // Width of the operation field.
    localparam int OP_W = 2;

    // Operation codes carried by an input beat.
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_SEARCH = 2'd2
    } op_t;

endpackage

>>> src/skse_key_ram.sv
// ----------------------------------------------------------------------------
// skse_key_ram
// Key storage: one write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module skse_key_ram
    import skse_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_LETTERS = 10
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0]       wr_addr,
    input  logic [LETTER_BITS*KEY_LETTERS-1:0]   wr_data,
    input  logic                                 rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0]       rd_addr,
    output logic [LETTER_BITS*KEY_LETTERS-1:0]   rd_data
);

    localparam int KEY_W = LETTER_BITS * KEY_LETTERS;

    logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    // Write port, used by appends.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, used by the searcher.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/skse_searcher.sv
// ----------------------------------------------------------------------------
// skse_searcher
// Runs the lower bound and upper bound binary searches over the key memory,
// one probe per cycle, and holds the result beat for the output channel.
// ----------------------------------------------------------------------------
module skse_searcher
    import skse_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_LETTERS = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [LETTER_BITS*KEY_LETTERS-1:0]   key_in,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]     n_in,
    output logic                                 idle,
    output logic                                 rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]       rd_addr,
    input  logic [LETTER_BITS*KEY_LETTERS-1:0]   rd_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_found,
    output logic [$clog2(TABLE_DEPTH)-1:0]       m_first_index,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]     m_match_count
);

    localparam int KEY_W  = LETTER_BITS * KEY_LETTERS;
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOWER = 4'b0010,
        ST_UPPER = 4'b0100,
        ST_DONE  = 4'b1000
    } srch_state_t;

    srch_state_t        state_reg, state_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   lower_reg, lower_next;
    logic [CNT_W-1:0]   upper_reg, upper_next;
    logic               m_valid_reg, m_valid_next;
    logic               found_reg, found_next;
    logic [ADDR_W-1:0]  first_reg, first_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               go_right;
    logic [CNT_W-1:0]   mid_cur;
    logic [CNT_W-1:0]   step_lo;
    logic [CNT_W-1:0]   step_hi;
    logic [CNT_W-1:0]   rd_mid;
    logic               range_ok;
    logic [CNT_W-1:0]   range_len;

    // The probed entry of the current window is in rd_data; decide which half remains.
    always_comb begin
        mid_cur  = lo_reg + ((hi_reg - lo_reg) >> 1);
        go_right = (state_reg == ST_UPPER) ? (rd_data <= key_reg) : (rd_data < key_reg);
        step_lo  = go_right ? (mid_cur + CNT_W'(1)) : lo_reg;
        step_hi  = go_right ? hi_reg : mid_cur;
    end

    // The equal range is the gap between the two bounds, empty when unordered.
    always_comb begin
        range_ok  = upper_reg > lower_reg;
        range_len = upper_reg - lower_reg;
    end

    // Sequencer: every cycle in a search state has a fresh read in flight.
    always_comb begin
        state_next   = state_reg;
        key_next     = key_reg;
        n_next       = n_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        lower_next   = lower_reg;
        upper_next   = upper_reg;
        m_valid_next = m_valid_reg;
        found_next   = found_reg;
        first_next   = first_reg;
        count_next   = count_reg;
        rd_en        = 1'b0;
        rd_mid       = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    key_next   = key_in;
                    n_next     = n_in;
                    lower_next = '0;
                    upper_next = '0;
                    if (n_in != '0) begin
                        lo_next    = '0;
                        hi_next    = n_in;
                        rd_en      = 1'b1;
                        rd_mid     = n_in >> 1;
                        state_next = ST_LOWER;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_LOWER: begin
                if (step_lo < step_hi) begin
                    lo_next = step_lo;
                    hi_next = step_hi;
                    rd_en   = 1'b1;
                    rd_mid  = step_lo + ((step_hi - step_lo) >> 1);
                end else begin
                    // Lower bound settled; the upper search restarts on the whole table.
                    lower_next = step_lo;
                    lo_next    = '0;
                    hi_next    = n_reg;
                    rd_en      = 1'b1;
                    rd_mid     = n_reg >> 1;
                    state_next = ST_UPPER;
                end
            end
            ST_UPPER: begin
                if (step_lo < step_hi) begin
                    lo_next = step_lo;
                    hi_next = step_hi;
                    rd_en   = 1'b1;
                    rd_mid  = step_lo + ((step_hi - step_lo) >> 1);
                end else begin
                    upper_next = step_lo;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Load the result beat once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    found_next   = range_ok;
                    first_next   = range_ok ? lower_reg[ADDR_W-1:0] : '0;
                    count_next   = range_ok ? range_len : '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Search window and result payload.
    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        n_reg     <= n_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        lower_reg <= lower_next;
        upper_reg <= upper_next;
        found_reg <= found_next;
        first_reg <= first_next;
        count_reg <= count_next;
    end

    assign idle          = (state_reg == ST_IDLE);
    assign rd_addr       = rd_mid[ADDR_W-1:0];
    assign m_valid       = m_valid_reg;
    assign m_found       = found_reg;
    assign m_first_index = first_reg;
    assign m_match_count = count_reg;

endmodule

>>> src/sorted_key_equal_range_search_core.sv
// ----------------------------------------------------------------------------
// sorted_key_equal_range_search_core
// Sorted key table with clear, append and equal range search.
// ----------------------------------------------------------------------------
// A search beat runs two binary searches (first entry not below the key, then
// first entry above it) over the n stored entries, one probe per cycle through
// the single read port of the key memory, and no new beat is taken until the
// search has loaded its result into the output register.
// A finished result waits in the output register while the next beat is taken.
// Appends past TABLE_DEPTH entries are dropped, operation code 3 is ignored,
// and only searches produce a result beat. Keys are compared as unsigned
// numbers; appends are expected in ascending order.
`include "sorted_key_equal_range_search_core_macros.svh"

module sorted_key_equal_range_search_core
    import skse_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_LETTERS = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [OP_W-1:0]                      s_operation,
    input  logic [LETTER_BITS*KEY_LETTERS-1:0]   s_item_key,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_found,
    output logic [$clog2(TABLE_DEPTH)-1:0]       m_first_index,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]     m_match_count
);

    localparam int KEY_W  = LETTER_BITS * KEY_LETTERS;
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  count_inc;
    logic              accept;
    logic              srch_start;
    logic              srch_idle;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [KEY_W-1:0]  rd_data;
    logic              table_full;
    logic              append_room;
    logic              result_ok;

    // A beat is taken whenever the searcher is not busy.
    assign s_ready     = srch_idle;
    assign accept      = s_valid && s_ready;
    assign table_full  = (count_reg >= CNT_W'(TABLE_DEPTH));
    assign srch_start  = accept && (op_t'(s_operation) == OP_SEARCH);
    assign count_inc   = count_reg + CNT_W'(1);
    assign append_room = accept && (op_t'(s_operation) == OP_APPEND) && !table_full;

    // Entry count update and append write. A search starts only from idle, so
    // no write and read to the same entry fall in the same cycle.
    always_comb begin
        count_next = count_reg;
        wr_en      = 1'b0;
        if (accept) begin
            case (op_t'(s_operation))
                OP_CLEAR: begin
                    count_next = '0;
                end
                OP_APPEND: begin
                    if (!table_full) begin
                        wr_en      = 1'b1;
                        count_next = count_inc;
                    end
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Key storage.
    skse_key_ram #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_LETTERS (KEY_LETTERS)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (s_item_key),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Binary search sequencer and output register.
    skse_searcher #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_LETTERS (KEY_LETTERS)
    ) u_searcher (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (srch_start),
        .key_in        (s_item_key),
        .n_in          (count_reg),
        .idle          (srch_idle),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_first_index (m_first_index),
        .m_match_count (m_match_count)
    );

    // A result reports found exactly when its range is not empty, and index zero otherwise.
    assign result_ok = (m_found == (m_match_count != '0)) && (m_found || (m_first_index == '0));

    // The entry count never passes the table depth.
    `SKSE_ASSERT_SAME(a_count_max, aclk, aresetn, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH), "count above depth")

    // Every result beat is self-consistent.
    `SKSE_ASSERT_SAME(a_result_consistent, aclk, aresetn, m_valid, result_ok, "inconsistent result beat")

    // An append into a table with room grows the count by one.
    `SKSE_ASSERT_NEXT(a_append_grows, aclk, aresetn, append_room, count_reg == $past(count_inc), "append lost")

endmodule
